>>> design/tsc_pkg.sv
// Shared constants, codes and item types of the triggered sample capture block.
package tsc_pkg;

  localparam int BUFFER_WORDS     = 65536;
  localparam int FULL_MAX_SAMPLES = 2000;
  localparam int LONG_MAX_SAMPLES = 20000;

  localparam int BUF_AW      = $clog2(BUFFER_WORDS);
  localparam int SAMPLE_W    = 16;
  localparam int WADDR_W     = SAMPLE_W + 3;
  localparam int FULL_WORDS  = 7;
  localparam int LONG_WORDS  = 2;
  localparam int TRIG_THRESHOLD = 65;
  localparam int SCALE_STD   = 1000;
  localparam int SCALE_ACC   = 100;
  localparam int PROD_W      = 43;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_ARM   = 2'd1;
  localparam logic [1:0] ACT_ABORT = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [1:0] CFG_TRIGGER_MODE = 2'd0;
  localparam logic [1:0] CFG_LONG_MODE    = 2'd1;
  localparam logic [1:0] CFG_SAMPLE_LIMIT = 2'd2;

  localparam logic [1:0] TRIG_IMMEDIATE = 2'd0;
  localparam logic [1:0] TRIG_REF_POS   = 2'd1;

  localparam logic [1:0] STAT_IDLE   = 2'd0;
  localparam logic [1:0] STAT_ACTIVE = 2'd1;
  localparam logic [1:0] STAT_DONE   = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_WAIT = 4'b0010,
    PH_CAPT = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] ref_position;
    logic signed [31:0] position;
    logic signed [31:0] ref_velocity;
    logic signed [31:0] velocity;
    logic signed [31:0] ref_acceleration;
    logic signed [31:0] voltage;
    logic signed [31:0] motor_current;
    logic [15:0]        read_address;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [1:0]  capture_status;
    logic [15:0] sample_count;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic [BUF_AW-1:0] addr;
    logic [15:0]       data;
  } wr_req_t;

  typedef struct packed {
    logic seq_busy;
    logic busy;
  } wr_stat_t;

endpackage

>>> design/tsc_wr.sv
// Write sequencer that scales one captured sample and stores its words one per cycle.
module tsc_wr (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              long_sel,
  input  logic [15:0]       sample_idx,
  input  tsc_pkg::in_item_t sample,
  output tsc_pkg::wr_req_t  wr,
  output tsc_pkg::wr_stat_t stat
);
  import tsc_pkg::*;

  in_item_t                  smp_r;
  logic                      long_r;
  logic [2:0]                cnt_r;
  logic [2:0]                wsel_r;
  logic [WADDR_W-1:0]        addr_r;
  logic                      pvalid_r;
  logic [WADDR_W-1:0]        paddr_r;
  logic signed [PROD_W-1:0]  prod_r;

  logic [WADDR_W-1:0]        base;
  logic signed [31:0]        chan;
  logic signed [10:0]        scl;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [PROD_W-1:0]  adj;
  logic signed [PROD_W-1:0]  q;

  assign base = long_sel ? WADDR_W'({sample_idx, 1'b0})
                         : WADDR_W'({sample_idx, 3'b000}) - WADDR_W'(sample_idx);

  always_comb begin
    chan = smp_r.voltage;
    if (long_r) begin
      chan = (wsel_r == 3'd0) ? smp_r.voltage : smp_r.velocity;
    end else begin
      case (wsel_r)
        3'd0:    chan = smp_r.ref_position;
        3'd1:    chan = smp_r.position;
        3'd2:    chan = smp_r.ref_velocity;
        3'd3:    chan = smp_r.velocity;
        3'd4:    chan = smp_r.ref_acceleration;
        3'd5:    chan = smp_r.voltage;
        3'd6:    chan = smp_r.motor_current;
        default: chan = smp_r.voltage;
      endcase
    end
    scl = (!long_r && wsel_r == 3'd4) ? $signed(11'(SCALE_ACC)) : $signed(11'(SCALE_STD));
    prod_nxt = chan * scl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      pvalid_r <= 1'b0;
    end else begin
      pvalid_r <= (cnt_r != 3'd0);
      if (start) begin
        cnt_r <= long_sel ? 3'(LONG_WORDS) : 3'(FULL_WORDS);
      end else if (cnt_r != 3'd0) begin
        cnt_r <= cnt_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      smp_r  <= sample;
      long_r <= long_sel;
      wsel_r <= '0;
      addr_r <= base;
    end else if (cnt_r != 3'd0) begin
      wsel_r <= wsel_r + 3'd1;
      addr_r <= addr_r + WADDR_W'(1);
    end
    prod_r  <= prod_nxt;
    paddr_r <= addr_r;
  end

  // Shift with truncation toward zero, then clamp to the int16 range.
  always_comb begin
    adj = prod_r + (prod_r[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
    q   = adj >>> 16;
    wr.en   = pvalid_r && (paddr_r < WADDR_W'(BUFFER_WORDS));
    wr.addr = paddr_r[BUF_AW-1:0];
    if (q > PROD_W'(32767)) begin
      wr.data = 16'h7FFF;
    end else if (q < -PROD_W'(32768)) begin
      wr.data = 16'h8000;
    end else begin
      wr.data = q[15:0];
    end
  end

  assign stat.seq_busy = (cnt_r != 3'd0);
  assign stat.busy     = (cnt_r != 3'd0) || pvalid_r;

endmodule

>>> design/triggered_sample_capture.sv
// Triggered sample capture: arm, abort, sample tick and buffer read over one item channel.
// Every item yields exactly one result, returned through a result register and an output
// register, so a new item is taken while a result waits. Arm, abort, reads and ticks that
// capture nothing are taken one per cycle while the output is not held back. A tick that
// captures in full mode stores seven words through the single write port of the buffer
// memory, so the next capturing tick waits until the sequencer has issued them all (two in
// long mode), and a read waits until the last scaled word is written. The buffer needs
// no clearing after reset.
module triggered_sample_capture (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tsc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tsc_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import tsc_pkg::*;

  logic [1:0]  cfg_trig_r;
  logic        cfg_long_r;
  logic [15:0] cfg_limit_r;

  phase_t             phase_r, phase_nxt;
  logic [15:0]        idx_r, idx_nxt;
  logic [15:0]        limit_r, limit_nxt;
  logic               long_r, long_nxt;
  logic [1:0]         trig_r, trig_nxt;
  logic signed [31:0] base_r, base_nxt;
  logic               taken_r, taken_nxt;

  logic               a_valid_r;
  logic               a_rd_r;
  logic [1:0]         a_status_r;
  logic [15:0]        a_count_r;
  logic               b_valid_r;
  out_item_t          b_r;
  logic [15:0]        mem_q_r;
  logic [15:0]        mem [BUFFER_WORDS];

  logic               in_acc;
  logic               a_move;
  logic               is_read;
  logic               capture;
  logic               fire;
  logic signed [31:0] cur;
  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [15:0]        max_lim;
  logic [15:0]        idx_inc;
  logic [1:0]         status_nxt;
  logic               rd_hit;
  wr_req_t            wr;
  wr_stat_t           wst;

  assign cur     = (trig_r == TRIG_REF_POS) ? in_data.ref_position : in_data.voltage;
  assign diff    = {cur[31], cur} - {base_r[31], base_r};
  assign mag     = diff[32] ? 33'(-diff) : 33'(diff);
  assign fire    = taken_r && (mag > 33'(TRIG_THRESHOLD));
  assign is_read = (in_data.action == ACT_READ);
  assign capture = (in_data.action == ACT_TICK) &&
                   ((phase_r == PH_CAPT) || (phase_r == PH_WAIT && fire));
  assign idx_inc = idx_r + 16'd1;
  assign max_lim = cfg_long_r ? 16'(LONG_MAX_SAMPLES) : 16'(FULL_MAX_SAMPLES);
  assign rd_hit  = ({1'b0, in_data.read_address} < 17'(BUFFER_WORDS));

  assign a_move   = a_valid_r && (!b_valid_r || out_ready);
  assign in_ready = (!a_valid_r || a_move) && !(is_read && wst.busy) &&
                    !(capture && wst.seq_busy);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    limit_nxt = limit_r;
    long_nxt  = long_r;
    trig_nxt  = trig_r;
    base_nxt  = base_r;
    taken_nxt = taken_r;
    if (in_acc) begin
      case (in_data.action)
        ACT_TICK: begin
          if (phase_r == PH_WAIT && !taken_r) begin
            base_nxt  = cur;
            taken_nxt = 1'b1;
          end
          if (capture) begin
            idx_nxt   = idx_inc;
            phase_nxt = (idx_inc >= limit_r) ? PH_DONE : PH_CAPT;
          end
        end
        ACT_ARM: begin
          long_nxt  = cfg_long_r;
          limit_nxt = (cfg_limit_r != 16'd0 && cfg_limit_r <= max_lim) ? cfg_limit_r : max_lim;
          trig_nxt  = cfg_trig_r;
          idx_nxt   = '0;
          taken_nxt = 1'b0;
          phase_nxt = (cfg_trig_r == TRIG_IMMEDIATE) ? PH_CAPT : PH_WAIT;
        end
        ACT_ABORT: begin
          phase_nxt = PH_IDLE;
          idx_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
    case (phase_nxt)
      PH_IDLE: status_nxt = STAT_IDLE;
      PH_DONE: status_nxt = STAT_DONE;
      default: status_nxt = STAT_ACTIVE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_trig_r  <= '0;
      cfg_long_r  <= 1'b0;
      cfg_limit_r <= '0;
      phase_r     <= PH_IDLE;
      idx_r       <= '0;
      limit_r     <= 16'(FULL_MAX_SAMPLES);
      long_r      <= 1'b0;
      trig_r      <= '0;
      base_r      <= '0;
      taken_r     <= 1'b0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRIGGER_MODE: cfg_trig_r  <= cfg_wdata[1:0];
          CFG_LONG_MODE:    cfg_long_r  <= cfg_wdata[0];
          CFG_SAMPLE_LIMIT: cfg_limit_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      limit_r <= limit_nxt;
      long_r  <= long_nxt;
      trig_r  <= trig_nxt;
      base_r  <= base_nxt;
      taken_r <= taken_nxt;
      if (in_acc) begin
        a_valid_r <= 1'b1;
      end else if (a_move) begin
        a_valid_r <= 1'b0;
      end
      if (a_move) begin
        b_valid_r <= 1'b1;
      end else if (out_ready) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_rd_r     <= is_read && rd_hit;
      a_status_r <= status_nxt;
      a_count_r  <= idx_nxt;
    end
    if (a_move) begin
      b_r.read_data      <= a_rd_r ? mem_q_r : 16'd0;
      b_r.capture_status <= a_status_r;
      b_r.sample_count   <= a_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (in_acc && is_read) begin
      mem_q_r <= mem[in_data.read_address[BUF_AW-1:0]];
    end
  end

  tsc_wr u_wr (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc && capture),
    .long_sel   (long_r),
    .sample_idx (idx_r),
    .sample     (in_data),
    .wr         (wr),
    .stat       (wst)
  );

  assign out_valid = b_valid_r;
  assign out_data  = b_r;

`ifndef SYNTH
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(phase_r))
    else $error("Capture phase is not one-hot.");
  a_read_after_writes: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_read |-> !wr.en && !wst.busy)
    else $error("Buffer read accepted while sample words are still being written.");
  a_capt_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CAPT |-> idx_r < limit_r)
    else $error("Capturing with the sample index at or beyond the limit.");
  a_done_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |-> idx_r == limit_r)
    else $error("Capture finished with a sample count other than the limit.");
  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && capture |=> !$past(wst.seq_busy))
    else $error("Capture started while the write sequencer was busy.");
`endif

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the triggered sample capture block.
`timescale 1ns / 1ps

module testbench;
  import tsc_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam logic [1:0] TRIG_VOLT_ALT = 2'd3;
  localparam int RX_OPEN = 0;
  localparam int RX_HALF = 1;
  localparam int SETTLE_CYCLES = 10;
  localparam int ITEM_TARGET = 650;

  class capture_scoreboard;
    logic [1:0]  trig_cfg = TRIG_IMMEDIATE;
    logic        long_cfg = 1'b0;
    logic [15:0] limit_cfg = '0;
    phase_t      phase = PH_IDLE;
    logic [15:0] sample_index = '0;
    logic [15:0] effective_limit = 16'(FULL_MAX_SAMPLES);
    logic        channels_long = 1'b0;
    logic [1:0]  latched_trigger = TRIG_IMMEDIATE;
    longint      baseline = 0;
    bit          baseline_taken = 0;
    logic [15:0] words [int];
    int          filled [$];
    out_item_t   pending [$];
    int          errors = 0;

    function void write_config(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_TRIGGER_MODE: trig_cfg = data[1:0];
        CFG_LONG_MODE: long_cfg = data[0];
        CFG_SAMPLE_LIMIT: limit_cfg = data;
        default: ;
      endcase
    endfunction

    function logic [15:0] scale_channel(logic [31:0] x, int s);
      longint q;
      q = (longint'($signed(x)) * s) / 65536;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function void store_word(int addr, logic [15:0] w);
      if (addr < BUFFER_WORDS) begin
        if (!words.exists(addr)) filled.push_back(addr);
        words[addr] = w;
      end
    endfunction

    function void capture_tick(in_item_t it);
      longint cur;
      longint d;
      int base;
      if (phase == PH_IDLE || phase == PH_DONE) return;
      if (phase == PH_WAIT) begin
        cur = (latched_trigger == TRIG_REF_POS) ? longint'($signed(it.ref_position))
                                                : longint'($signed(it.voltage));
        if (!baseline_taken) begin
          baseline = cur;
          baseline_taken = 1;
          return;
        end
        d = cur - baseline;
        if (d < 0) d = -d;
        if (d <= TRIG_THRESHOLD) return;
        phase = PH_CAPT;
      end
      if (channels_long) begin
        base = int'(sample_index) * LONG_WORDS;
        store_word(base, scale_channel(it.voltage, SCALE_STD));
        store_word(base + 1, scale_channel(it.velocity, SCALE_STD));
      end else begin
        base = int'(sample_index) * FULL_WORDS;
        store_word(base, scale_channel(it.ref_position, SCALE_STD));
        store_word(base + 1, scale_channel(it.position, SCALE_STD));
        store_word(base + 2, scale_channel(it.ref_velocity, SCALE_STD));
        store_word(base + 3, scale_channel(it.velocity, SCALE_STD));
        store_word(base + 4, scale_channel(it.ref_acceleration, SCALE_ACC));
        store_word(base + 5, scale_channel(it.voltage, SCALE_STD));
        store_word(base + 6, scale_channel(it.motor_current, SCALE_STD));
      end
      sample_index = sample_index + 16'd1;
      if (sample_index >= effective_limit) phase = PH_DONE;
    endfunction

    function void note_item(in_item_t it);
      out_item_t res;
      int maxn;
      res = '0;
      case (it.action)
        ACT_TICK: capture_tick(it);
        ACT_ARM: begin
          channels_long = long_cfg;
          maxn = channels_long ? LONG_MAX_SAMPLES : FULL_MAX_SAMPLES;
          if (limit_cfg != 0 && int'(limit_cfg) <= maxn) effective_limit = limit_cfg;
          else effective_limit = maxn[15:0];
          latched_trigger = trig_cfg;
          sample_index = '0;
          baseline_taken = 0;
          phase = (latched_trigger == TRIG_IMMEDIATE) ? PH_CAPT : PH_WAIT;
        end
        ACT_ABORT: begin
          phase = PH_IDLE;
          sample_index = '0;
        end
        default: begin
          if (words.exists(int'(it.read_address))) res.read_data = words[int'(it.read_address)];
        end
      endcase
      if (phase == PH_DONE) res.capture_status = STAT_DONE;
      else if (phase == PH_IDLE) res.capture_status = STAT_IDLE;
      else res.capture_status = STAT_ACTIVE;
      res.sample_count = sample_index;
      pending.push_back(res);
    endfunction

    task report(string msg);
      if (errors < 50) $display("capture check: %s", msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with none outstanding: %p", got));
        return;
      end
      want = pending.pop_front();
      if (got.read_data !== want.read_data)
        report($sformatf("read_data got %h want %h", got.read_data, want.read_data));
      if (got.capture_status !== want.capture_status)
        report($sformatf("capture_status got %0d want %0d",
                         got.capture_status, want.capture_status));
      if (got.sample_count !== want.sample_count)
        report($sformatf("sample_count got %0d want %0d", got.sample_count, want.sample_count));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  capture_scoreboard sb;
  int burst_left = 0;
  int items_sent = 0;
  int rx_cycle = 0;

  triggered_sample_capture u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((rx_cycle / 250) % 3 == RX_OPEN) begin
      out_ready <= 1'b1;
    end else if ((rx_cycle / 250) % 3 == RX_HALF) begin
      out_ready <= ($urandom_range(0, 1) == 1);
    end else begin
      out_ready <= ($urandom_range(0, 3) == 0);
    end
    rx_cycle <= rx_cycle + 1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  function automatic int rand_q16();
    int v;
    case ($urandom_range(0, 9))
      0: v = 32'h7FFFFFFF;
      1: v = 32'h80000000;
      2, 3, 4: v = $urandom;
      5: v = 2147418 + $urandom_range(0, 200) - 100;
      6: v = 21474180 + $urandom_range(0, 2000) - 1000;
      default: v = $urandom_range(0, 4194304) - 2097152;
    endcase
    if ($urandom_range(0, 1) == 1 && v != 32'h80000000) v = -v;
    return v;
  endfunction

  function automatic in_item_t rand_item(logic [1:0] act);
    in_item_t it;
    it.action = act;
    it.ref_position = rand_q16();
    it.position = rand_q16();
    it.ref_velocity = rand_q16();
    it.velocity = rand_q16();
    it.ref_acceleration = rand_q16();
    it.voltage = rand_q16();
    it.motor_current = rand_q16();
    it.read_address = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  function automatic in_item_t read_item(int addr);
    in_item_t it;
    it = rand_item(ACT_READ);
    it.read_address = addr[15:0];
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_capture(logic [1:0] trig, logic lng, logic [15:0] limit, bit spare);
    logic [1:0]  idx [4];
    logic [15:0] val [4];
    logic [15:0] noise;
    int n;
    noise = 16'($urandom);
    n = 0;
    if (spare) begin
      idx[n] = CFG_SPARE;
      val[n] = noise;
      n++;
    end
    idx[n] = CFG_TRIGGER_MODE;
    val[n] = {noise[13:0], trig};
    n++;
    idx[n] = CFG_LONG_MODE;
    val[n] = {noise[15:1], lng};
    n++;
    idx[n] = CFG_SAMPLE_LIMIT;
    val[n] = limit;
    n++;
    cfg_we <= 1'b1;
    for (int i = 0; i < n; i++) begin
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.write_config(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_session(logic [1:0] trig, logic lng, logic [15:0] limit, int len);
    in_item_t it;
    int tick_no;
    int quiet;
    int w0;
    int r;
    int watched;
    int jump;
    settle();
    program_capture(trig, lng, limit, $urandom_range(0, 3) == 0);
    send_item(rand_item(ACT_ARM));
    tick_no = 0;
    quiet = $urandom_range(0, 4);
    w0 = $urandom_range(0, 1 << 30) - (1 << 29);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        it = rand_item(ACT_ABORT);
      end else if (r < 9) begin
        it = rand_item(ACT_ARM);
        tick_no = 0;
      end else if (r < 24 && sb.filled.size() != 0) begin
        it = read_item(sb.filled[$urandom_range(0, sb.filled.size() - 1)]);
      end else begin
        it = rand_item(ACT_TICK);
        if (trig != TRIG_IMMEDIATE && tick_no <= quiet + 1) begin
          jump = $urandom_range(0, 1) ? $urandom_range(66, 76) : $urandom_range(66, 1 << 28);
          if ($urandom_range(0, 1) == 1) jump = -jump;
          if (tick_no == 0) watched = w0;
          else if (tick_no <= quiet) watched = w0 + $urandom_range(0, 130) - 65;
          else watched = w0 + jump;
          if (trig == TRIG_REF_POS) it.ref_position = watched;
          else it.voltage = watched;
        end
        tick_no++;
      end
      send_item(it);
    end
  endtask

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    in_item_t it;
    int rd_list [5] = '{0, 4, 7, 11, 13};
    logic [1:0] trig;
    logic lng;
    logic [15:0] limit;
    int n;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(rand_item(ACT_TICK));
    send_item(rand_item(ACT_ABORT));

    settle();
    program_capture(TRIG_IMMEDIATE, 1'b0, 16'd2, 1'b1);
    send_item(rand_item(ACT_ARM));
    it = rand_item(ACT_TICK);
    it.ref_position = 32'h7FFFFFFF;
    it.position = 32'h80000000;
    it.ref_velocity = 2147418;
    it.velocity = -2147418;
    it.ref_acceleration = 32'h7FFFFFFF;
    it.voltage = -1;
    it.motor_current = 1;
    send_item(it);
    it.ref_position = 32'h80000000;
    it.position = 32'h7FFFFFFF;
    it.ref_velocity = -65;
    it.velocity = 65;
    it.ref_acceleration = 32'h80000000;
    it.voltage = 0;
    it.motor_current = -66;
    send_item(it);
    send_item(rand_item(ACT_TICK));
    foreach (rd_list[i]) send_item(read_item(rd_list[i]));

    settle();
    program_capture(TRIG_REF_POS, 1'b1, 16'd3, 1'b0);
    send_item(rand_item(ACT_ARM));
    it = rand_item(ACT_TICK);
    it.ref_position = 1000;
    send_item(it);
    it.ref_position = 1065;
    send_item(it);
    it.ref_position = 935;
    send_item(it);
    it.ref_position = 1066;
    send_item(it);
    send_item(rand_item(ACT_TICK));
    send_item(rand_item(ACT_TICK));
    send_item(read_item(0));
    send_item(read_item(5));

    // The watched voltage swings from one end of its range to the other.
    settle();
    program_capture(TRIG_VOLT_ALT, 1'b0, 16'd0, 1'b0);
    send_item(rand_item(ACT_ARM));
    it = rand_item(ACT_TICK);
    it.voltage = 32'h80000000;
    send_item(it);
    it.voltage = 32'h7FFFFFFF;
    send_item(it);
    send_item(rand_item(ACT_ARM));
    send_item(rand_item(ACT_ABORT));
    send_item(read_item(1));

    n = 0;
    while (items_sent < ITEM_TARGET) begin
      trig = 2'($urandom_range(0, 3));
      lng = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0: limit = 16'd0;
        1: limit = 16'hFFFF;
        2: limit = lng ? 16'(LONG_MAX_SAMPLES) : 16'(FULL_MAX_SAMPLES);
        3: limit = lng ? 16'(LONG_MAX_SAMPLES + 1) : 16'(FULL_MAX_SAMPLES + 1);
        default: limit = 16'($urandom_range(1, 12));
      endcase
      if (n == 0) begin
        lng = 1'b1;
        limit = 16'hFFFF;
      end
      run_session(trig, lng, limit, $urandom_range(15, 45));
      n++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> triggered_sample_capture.f
design/tsc_pkg.sv
design/tsc_wr.sv
design/triggered_sample_capture.sv
tb/testbench.sv
